// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JAC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, disabled during reset.
`define JAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

// File: rtl/jac_pkg.sv
// Shared types and constants of the joystick axis conditioner.
`default_nettype none

package jac_pkg;

	localparam int RawW       = 12;
	localparam int ValW       = 10;
	localparam int OffW       = 12;
	localparam int TrimW      = 11;
	localparam int SumW       = 15;
	localparam int ScaleMul   = 1000;
	localparam int ScaleDiv   = 4095;
	localparam int ScaleShift = 12;
	localparam int ProdW      = RawW + ValW;
	localparam int ValMax     = 1000;
	localparam int Center     = 500;
	localparam int TrimStep   = 10;
	localparam int TrimLim    = 1000;
	localparam int OffLim     = 2047;
	localparam int Lanes      = 4;

	typedef enum logic {
		KIND_STICK = 1'b0,
		KIND_KEY   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		KEY_NONE   = 3'd0,
		KEY_UP     = 3'd1,
		KEY_DN     = 3'd2,
		KEY_LT     = 3'd3,
		KEY_RT     = 3'd4,
		KEY_LPRESS = 3'd5,
		KEY_RPRESS = 3'd6,
		KEY_RLONG  = 3'd7
	} key_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_APPLY
	} cal_state_t;

	typedef struct packed {
		logic clear;
		logic acc;
		logic div;
		logic apply;
	} lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/jac_scale_lane.sv
// One axis of the two-stage raw-to-0..1000 scaling pipe.
`default_nettype none

module jac_scale_lane (
	input  logic                      clk,
	input  logic                      en_s1,
	input  logic                      en_s2,
	input  logic [jac_pkg::RawW-1:0]  raw,
	output logic [jac_pkg::ValW-1:0]  scaled_s2
);

	localparam int PW = jac_pkg::ProdW;
	localparam int SH = jac_pkg::ScaleShift;
	localparam int VW = jac_pkg::ValW;
	localparam int RW = SH + 1;

	logic [PW-1:0] prod_s1;
	logic [VW-1:0] q0;
	logic [RW-1:0] rem;
	logic [VW-1:0] quot;
	logic [VW-1:0] scaled_d;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= PW'(raw) * PW'(jac_pkg::ScaleMul);
		end
	end

	// floor(p/4095) is floor(p/4096) or one more
	always_comb begin
		q0       = prod_s1[PW-1:SH];
		rem      = RW'(prod_s1[SH-1:0]) + RW'(q0);
		quot     = (rem >= RW'(jac_pkg::ScaleDiv)) ? q0 + VW'(1) : q0;
		scaled_d = VW'(jac_pkg::ValMax) - quot;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			scaled_s2 <= scaled_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/jac_axis_lane.sv
// One axis of the state stage: offset, trim, clamp and calibration sum.
`default_nettype none

module jac_axis_lane #(
	parameter int CAL_SAMPLES = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jac_pkg::lane_ctl_t               ctl,
	input  logic [jac_pkg::ValW-1:0]         scaled,
	input  logic signed [jac_pkg::TrimW-1:0] trim,
	input  logic [jac_pkg::ValW-1:0]         center,
	output logic [jac_pkg::ValW-1:0]         value
);

	localparam int OW       = jac_pkg::OffW;
	localparam int SW       = jac_pkg::SumW;
	localparam int VW       = jac_pkg::ValW;
	localparam int XW       = OW + 2;
	localparam int MagW     = SW - 1;
	localparam int DivShift = MagW + 5;
	localparam int DivMul   = (2 ** DivShift + CAL_SAMPLES - 1) / CAL_SAMPLES;
	localparam int MulW     = DivShift + 1;
	localparam int QPW      = MagW + MulW;
	localparam int AW       = SW + 1;

	logic signed [OW-1:0] offset_q;
	logic signed [SW-1:0] sum_q;
	logic [QPW-1:0]       quot_prod_q;
	logic                 neg_q;

	logic signed [XW-1:0] raw_val;
	logic signed [SW-1:0] acc_term;
	logic [MagW-1:0]      mag;
	logic [MagW-1:0]      quot;
	logic signed [SW-1:0] quot_s;
	logic signed [AW-1:0] off_sum;
	logic signed [OW-1:0] off_new;

	always_comb begin
		raw_val = $signed(XW'(scaled)) - XW'(offset_q) + XW'(trim);
		if (raw_val < 0) begin
			value = '0;
		end else if (raw_val > XW'(jac_pkg::ValMax)) begin
			value = VW'(jac_pkg::ValMax);
		end else begin
			value = raw_val[VW-1:0];
		end
		acc_term = $signed(SW'(value)) - $signed(SW'(center));
	end

	// sum / CAL_SAMPLES, truncated toward zero, by reciprocal multiply
	always_comb begin
		mag     = sum_q[SW-1] ? MagW'(-sum_q) : MagW'(sum_q);
		quot    = MagW'(quot_prod_q >> DivShift);
		quot_s  = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		off_sum = AW'(offset_q) + AW'(quot_s);
		if (off_sum > AW'(jac_pkg::OffLim)) begin
			off_new = OW'(jac_pkg::OffLim);
		end else if (off_sum < -AW'(jac_pkg::OffLim)) begin
			off_new = -OW'(jac_pkg::OffLim);
		end else begin
			off_new = off_sum[OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			sum_q    <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + acc_term;
		end else if (ctl.apply) begin
			sum_q    <= '0;
			offset_q <= off_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div) begin
			quot_prod_q <= QPW'(mag) * QPW'(DivMul);
			neg_q       <= sum_q[SW-1];
		end
	end

endmodule

`default_nettype wire

// File: rtl/jac_ctrl.sv
// Key handling, trims, flags and the calibration sequencer.
`default_nettype none

module jac_ctrl #(
	parameter int CAL_SAMPLES = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  jac_pkg::kind_t                   kind,
	input  jac_pkg::key_t                    key_code,
	output logic                             open,
	output jac_pkg::lane_ctl_t               ctl,
	output logic signed [jac_pkg::TrimW-1:0] pitch_trim,
	output logic signed [jac_pkg::TrimW-1:0] roll_trim,
	output logic                             shutdown,
	output logic                             alt_hold,
	output logic                             cal_active
);

	localparam int TW   = jac_pkg::TrimW;
	localparam int CntW = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

	function automatic logic signed [TW-1:0] trim_step(
		input logic signed [TW-1:0] t,
		input logic                 up
	);
		logic signed [TW:0] s;
		s = up ? (TW + 1)'(t) + (TW + 1)'(jac_pkg::TrimStep)
		       : (TW + 1)'(t) - (TW + 1)'(jac_pkg::TrimStep);
		if (s > (TW + 1)'(jac_pkg::TrimLim)) begin
			return TW'(jac_pkg::TrimLim);
		end else if (s < -(TW + 1)'(jac_pkg::TrimLim)) begin
			return -TW'(jac_pkg::TrimLim);
		end
		return s[TW-1:0];
	endfunction

	jac_pkg::cal_state_t state_q;
	jac_pkg::cal_state_t state_d;

	logic signed [TW-1:0] pitch_trim_q;
	logic signed [TW-1:0] roll_trim_q;
	logic                 shutdown_q;
	logic                 alt_hold_q;
	logic                 cal_active_q;
	logic [CntW-1:0]      cnt_q;

	logic sample_fire;
	logic key_fire;
	logic last;

	assign sample_fire = fire && (kind == jac_pkg::KIND_STICK);
	assign key_fire    = fire && (kind == jac_pkg::KIND_KEY) && !cal_active_q;
	assign last        = sample_fire && cal_active_q && (cnt_q == CntW'(CAL_SAMPLES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			jac_pkg::ST_RUN: begin
				if (last) begin
					state_d = jac_pkg::ST_DIV;
				end
			end
			jac_pkg::ST_DIV:   state_d = jac_pkg::ST_APPLY;
			jac_pkg::ST_APPLY: state_d = jac_pkg::ST_RUN;
			default:           state_d = jac_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		open      = 1'b0;
		ctl.div   = 1'b0;
		ctl.apply = 1'b0;
		case (state_q)
			jac_pkg::ST_RUN:   open      = 1'b1;
			jac_pkg::ST_DIV:   ctl.div   = 1'b1;
			jac_pkg::ST_APPLY: ctl.apply = 1'b1;
			default:           open      = 1'b0;
		endcase
		ctl.clear = key_fire && (key_code == jac_pkg::KEY_RLONG);
		ctl.acc   = sample_fire && cal_active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= jac_pkg::ST_RUN;
			pitch_trim_q <= '0;
			roll_trim_q  <= '0;
			shutdown_q   <= 1'b0;
			alt_hold_q   <= 1'b0;
			cal_active_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			if (key_fire) begin
				case (key_code)
					jac_pkg::KEY_UP:     pitch_trim_q <= trim_step(pitch_trim_q, 1'b1);
					jac_pkg::KEY_DN:     pitch_trim_q <= trim_step(pitch_trim_q, 1'b0);
					jac_pkg::KEY_LT:     roll_trim_q  <= trim_step(roll_trim_q, 1'b0);
					jac_pkg::KEY_RT:     roll_trim_q  <= trim_step(roll_trim_q, 1'b1);
					jac_pkg::KEY_LPRESS: shutdown_q   <= 1'b1;
					jac_pkg::KEY_RPRESS: alt_hold_q   <= 1'b1;
					jac_pkg::KEY_RLONG: begin
						pitch_trim_q <= '0;
						roll_trim_q  <= '0;
						cnt_q        <= '0;
						cal_active_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (sample_fire && cal_active_q) begin
				if (last) begin
					cnt_q        <= '0;
					cal_active_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
		end
	end

	assign pitch_trim = pitch_trim_q;
	assign roll_trim  = roll_trim_q;
	assign shutdown   = shutdown_q;
	assign alt_hold   = alt_hold_q;
	assign cal_active = cal_active_q;

endmodule

`default_nettype wire

// File: rtl/joystick_axis_conditioner.sv
// Top level: four-lane stick conditioner with key trims and calibration.
//
// Input channel (in_valid/in_ready) carries either a stick transaction
// (kind 0, four raw 12-bit samples) or a key transaction (kind 1, key_code).
// Output channel (out_valid/out_ready) carries one conditioned transaction
// per stick transaction; key transactions produce none.
// A stick transaction passes the two scaling stages and the state stage into
// the output register. Throughput: one transaction per cycle when nothing
// stalls. The state stage pauses in its divide and apply states after the
// sample that completes a calibration, while each lane's offset register
// takes its averaged sum (reciprocal multiply, then add).
// Two scaling stages sit ahead of the state stage; each lane scales,
// offsets, trims and clamps its axis, and the output register merges lanes
// and flags. When the receiver stalls, the result waits in the output
// register, key transactions still drain, and stick transactions fill the
// two scaling stages before in_ready drops.
// Reset clears offsets, trims, flags, calibration state and the pipeline.

`default_nettype none

module joystick_axis_conditioner #(
	parameter int CAL_SAMPLES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [11:0] throttle_raw,
	input  logic [11:0] yaw_raw,
	input  logic [11:0] pitch_raw,
	input  logic [11:0] roll_raw,
	input  logic [2:0]  key_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  throttle_out,
	output logic [9:0]  yaw_out,
	output logic [9:0]  pitch_out,
	output logic [9:0]  roll_out,
	output logic        shutdown_flag,
	output logic        hold_altitude,
	output logic        calibrating
);

	localparam int RW = jac_pkg::RawW;
	localparam int VW = jac_pkg::ValW;
	localparam int TW = jac_pkg::TrimW;
	localparam int NL = jac_pkg::Lanes;

	logic valid_s1;
	logic valid_s2;
	jac_pkg::kind_t kind_s1;
	jac_pkg::kind_t kind_s2;
	jac_pkg::key_t  key_s1;
	jac_pkg::key_t  key_s2;

	logic in_fire;
	logic adv2;
	logic fire3;
	logic out_room;
	logic st_open;
	logic load_out;

	jac_pkg::lane_ctl_t   ctl;
	logic signed [TW-1:0] pitch_trim;
	logic signed [TW-1:0] roll_trim;
	logic                 shutdown;
	logic                 alt_hold;
	logic                 cal_active;

	logic [NL-1:0][RW-1:0]         raw_in;
	logic [NL-1:0][VW-1:0]         scaled_s2;
	logic [NL-1:0][VW-1:0]         lane_val;
	logic [NL-1:0][TW-1:0]         lane_trim;
	logic [NL-1:0][VW-1:0]         lane_center;

	logic          out_valid_q;
	logic [VW-1:0] throttle_q;
	logic [VW-1:0] yaw_q;
	logic [VW-1:0] pitch_q;
	logic [VW-1:0] roll_q;
	logic          shutdown_q;
	logic          alt_hold_q;
	logic          calibrating_q;

	assign out_room = !out_valid_q || out_ready;
	assign fire3    = valid_s2 && st_open && ((kind_s2 == jac_pkg::KIND_KEY) || out_room);
	assign adv2     = valid_s1 && (!valid_s2 || fire3);
	assign in_ready = !valid_s1 || adv2;
	assign in_fire  = in_valid && in_ready;
	assign load_out = fire3 && (kind_s2 == jac_pkg::KIND_STICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= 1'b1;
			end else if (fire3) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= jac_pkg::kind_t'(kind);
			key_s1  <= jac_pkg::key_t'(key_code);
		end
		if (adv2) begin
			kind_s2 <= kind_s1;
			key_s2  <= key_s1;
		end
	end

	assign raw_in      = {roll_raw, pitch_raw, yaw_raw, throttle_raw};
	assign lane_trim   = {roll_trim, pitch_trim, TW'(0), TW'(0)};
	assign lane_center = {VW'(jac_pkg::Center), VW'(jac_pkg::Center),
		VW'(jac_pkg::Center), VW'(0)};

	for (genvar i = 0; i < NL; i++) begin : g_lane
		jac_scale_lane u_scale (
			.clk       (clk),
			.en_s1     (in_fire),
			.en_s2     (adv2),
			.raw       (raw_in[i]),
			.scaled_s2 (scaled_s2[i])
		);

		jac_axis_lane #(
			.CAL_SAMPLES (CAL_SAMPLES)
		) u_axis (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.scaled (scaled_s2[i]),
			.trim   ($signed(lane_trim[i])),
			.center (lane_center[i]),
			.value  (lane_val[i])
		);
	end

	jac_ctrl #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire3),
		.kind       (kind_s2),
		.key_code   (key_s2),
		.open       (st_open),
		.ctl        (ctl),
		.pitch_trim (pitch_trim),
		.roll_trim  (roll_trim),
		.shutdown   (shutdown),
		.alt_hold   (alt_hold),
		.cal_active (cal_active)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			throttle_q    <= lane_val[0];
			yaw_q         <= lane_val[1];
			pitch_q       <= lane_val[2];
			roll_q        <= lane_val[3];
			shutdown_q    <= shutdown;
			alt_hold_q    <= alt_hold;
			calibrating_q <= cal_active;
		end
	end

	assign out_valid     = out_valid_q;
	assign throttle_out  = throttle_q;
	assign yaw_out       = yaw_q;
	assign pitch_out     = pitch_q;
	assign roll_out      = roll_q;
	assign shutdown_flag = shutdown_q;
	assign hold_altitude = alt_hold_q;
	assign calibrating   = calibrating_q;

endmodule

`default_nettype wire

// File: rtl/jac_chk.sv
// Port-level checker for the conditioner, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module jac_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] throttle_out,
	input logic [9:0] yaw_out,
	input logic [9:0] pitch_out,
	input logic [9:0] roll_out,
	input logic       shutdown_flag,
	input logic       hold_altitude
);

	logic all_in_range;

	assign all_in_range = (throttle_out <= 10'd1000) && (yaw_out <= 10'd1000) &&
		(pitch_out <= 10'd1000) && (roll_out <= 10'd1000);

	`JAC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`JAC_ASSERT_IMPL(a_out_range, clk, arst_n, out_valid, all_in_range)
	`JAC_ASSERT_NEXT(a_shutdown_sticky, clk, arst_n, out_valid && shutdown_flag, shutdown_flag)
	`JAC_ASSERT_NEXT(a_hold_sticky, clk, arst_n, out_valid && hold_altitude, hold_altitude)

endmodule

bind joystick_axis_conditioner jac_chk u_jac_chk (.*);

`default_nettype wire
